@@ hw/rtl/pabb_pkg.sv @@
// ----------------------------------------------------------------------------
// pabb_pkg
// shared widths, constants and stage payload types of the polygon area,
// orientation and bounding box core
// ----------------------------------------------------------------------------
package pabb_pkg;

  localparam int COORD_BITS     = 16;
  localparam int DIFF_BITS      = COORD_BITS + 1;
  localparam int PROD_BITS      = 2 * DIFF_BITS;
  localparam int CROSS_BITS     = PROD_BITS + 1;
  localparam int AREA_BITS      = 48;
  localparam int CNT_BITS       = 14;
  localparam int MAX_VERTICES   = 8192;
  localparam int MIN_FOR_ORIENT = 3;
  localparam int IN_BITS        = 2 * COORD_BITS;
  localparam int OUT_BITS       = AREA_BITS + 1 + 4 * COORD_BITS + CNT_BITS + 1;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [DIFF_BITS-1:0]  diff_t;
  typedef logic signed [PROD_BITS-1:0]  prod_t;
  typedef logic signed [AREA_BITS-1:0]  area_t;
  typedef logic [CNT_BITS-1:0]          cnt_t;

  typedef struct packed {
    coord_t min_x;
    coord_t max_x;
    coord_t min_y;
    coord_t max_y;
  } box_t;

  // tracker stage to accumulator stage
  typedef struct packed {
    logic  last;
    prod_t edge_a;
    prod_t edge_b;
    diff_t v1x;
    diff_t v1y;
    diff_t v2x;
    diff_t v2y;
    box_t  box;
    cnt_t  count;
    logic  ovf;
  } trk_t;

  // accumulator stage to finishing stage
  typedef struct packed {
    area_t area;
    prod_t cr_a;
    prod_t cr_b;
    box_t  box;
    cnt_t  count;
    logic  ovf;
  } acc_t;

  function automatic diff_t ext_c(coord_t v);
    return diff_t'(v);
  endfunction

endpackage

@@ hw/rtl/pabb_track.sv @@
// ----------------------------------------------------------------------------
// pabb_track
// per-vertex state: first, previous and top vertex, box, count; edge products
// ----------------------------------------------------------------------------
module pabb_track import pabb_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   s1_valid,
  input  coord_t s1_x,
  input  coord_t s1_y,
  input  logic   s1_last,
  input  logic   s3_rdy,
  output logic   s2_rdy,
  output logic   s2_valid_r,
  output trk_t   s2_r
);

  coord_t first_x_r, first_y_r, first_x_nxt, first_y_nxt;
  coord_t prev_x_r, prev_y_r;
  coord_t top_x_r, top_y_r, top_x_nxt, top_y_nxt;
  coord_t pred_x_r, pred_y_r, pred_x_nxt, pred_y_nxt;
  coord_t succ_x_r, succ_y_r, succ_x_nxt, succ_y_nxt;
  logic   succ_pend_r, succ_pend_nxt;
  logic   top_first_r, top_first_nxt;
  box_t   box_r, box_nxt;
  cnt_t   cnt_r, cnt_nxt;
  logic   ovf_r, ovf_nxt;
  logic   move;
  logic   start;
  coord_t pred_fin_x, pred_fin_y, succ_fin_x, succ_fin_y;
  diff_t  sum_a, dy_a, sum_b, dy_b;
  prod_t  edge_a, edge_b;

  assign s2_rdy = !s2_valid_r || s3_rdy;
  assign move   = s1_valid && s2_rdy;
  assign start  = (cnt_r == '0);

  // next tracking state
  always_comb begin
    first_x_nxt   = first_x_r;
    first_y_nxt   = first_y_r;
    top_x_nxt     = top_x_r;
    top_y_nxt     = top_y_r;
    pred_x_nxt    = pred_x_r;
    pred_y_nxt    = pred_y_r;
    succ_x_nxt    = succ_x_r;
    succ_y_nxt    = succ_y_r;
    succ_pend_nxt = succ_pend_r;
    top_first_nxt = top_first_r;
    box_nxt       = box_r;
    cnt_nxt       = cnt_r;
    ovf_nxt       = ovf_r;
    if (start) begin
      first_x_nxt   = s1_x;
      first_y_nxt   = s1_y;
      top_x_nxt     = s1_x;
      top_y_nxt     = s1_y;
      top_first_nxt = 1'b1;
      succ_pend_nxt = 1'b1;
      box_nxt       = '{min_x: s1_x, max_x: s1_x, min_y: s1_y, max_y: s1_y};
      cnt_nxt       = cnt_t'(1);
    end else begin
      if (s1_x < box_r.min_x) box_nxt.min_x = s1_x;
      if (s1_x > box_r.max_x) box_nxt.max_x = s1_x;
      if (s1_y < box_r.min_y) box_nxt.min_y = s1_y;
      if (s1_y > box_r.max_y) box_nxt.max_y = s1_y;
      if (s1_y > top_y_r) begin
        top_x_nxt     = s1_x;
        top_y_nxt     = s1_y;
        pred_x_nxt    = prev_x_r;
        pred_y_nxt    = prev_y_r;
        top_first_nxt = 1'b0;
        succ_pend_nxt = 1'b1;
      end else if (succ_pend_r) begin
        succ_x_nxt    = s1_x;
        succ_y_nxt    = s1_y;
        succ_pend_nxt = 1'b0;
      end
      if (cnt_r >= cnt_t'(MAX_VERTICES)) begin
        ovf_nxt = 1'b1;
      end else begin
        cnt_nxt = cnt_r + cnt_t'(1);
      end
    end
  end

  // neighbors of the top vertex as seen at the close
  assign pred_fin_x = top_first_nxt ? s1_x : pred_x_nxt;
  assign pred_fin_y = top_first_nxt ? s1_y : pred_y_nxt;
  assign succ_fin_x = succ_pend_nxt ? first_x_nxt : succ_x_nxt;
  assign succ_fin_y = succ_pend_nxt ? first_y_nxt : succ_y_nxt;

  // shoelace terms: previous edge and wrap edge back to the first vertex
  assign sum_a  = ext_c(prev_x_r) + ext_c(s1_x);
  assign dy_a   = ext_c(s1_y) - ext_c(prev_y_r);
  assign sum_b  = ext_c(s1_x) + ext_c(first_x_nxt);
  assign dy_b   = ext_c(first_y_nxt) - ext_c(s1_y);
  assign edge_a = start ? '0 : prod_t'(sum_a) * prod_t'(dy_a);
  assign edge_b = s1_last ? prod_t'(sum_b) * prod_t'(dy_b) : '0;

  // control state, cleared after the closing vertex
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      ovf_r       <= 1'b0;
      succ_pend_r <= 1'b0;
      top_first_r <= 1'b1;
      s2_valid_r  <= 1'b0;
    end else begin
      if (s2_rdy) begin
        s2_valid_r <= s1_valid;
      end
      if (move) begin
        if (s1_last) begin
          cnt_r       <= '0;
          ovf_r       <= 1'b0;
          succ_pend_r <= 1'b0;
          top_first_r <= 1'b1;
        end else begin
          cnt_r       <= cnt_nxt;
          ovf_r       <= ovf_nxt;
          succ_pend_r <= succ_pend_nxt;
          top_first_r <= top_first_nxt;
        end
      end
    end
  end

  // vertex payload state and stage register
  always_ff @(posedge clk) begin
    if (move) begin
      first_x_r   <= first_x_nxt;
      first_y_r   <= first_y_nxt;
      prev_x_r    <= s1_x;
      prev_y_r    <= s1_y;
      top_x_r     <= top_x_nxt;
      top_y_r     <= top_y_nxt;
      pred_x_r    <= pred_x_nxt;
      pred_y_r    <= pred_y_nxt;
      succ_x_r    <= succ_x_nxt;
      succ_y_r    <= succ_y_nxt;
      box_r       <= box_nxt;
      s2_r.last   <= s1_last;
      s2_r.edge_a <= edge_a;
      s2_r.edge_b <= edge_b;
      s2_r.v1x    <= ext_c(top_x_nxt) - ext_c(pred_fin_x);
      s2_r.v1y    <= ext_c(top_y_nxt) - ext_c(pred_fin_y);
      s2_r.v2x    <= ext_c(succ_fin_x) - ext_c(top_x_nxt);
      s2_r.v2y    <= ext_c(succ_fin_y) - ext_c(top_y_nxt);
      s2_r.box    <= box_nxt;
      s2_r.count  <= cnt_nxt;
      s2_r.ovf    <= ovf_nxt;
    end
  end

endmodule

@@ hw/rtl/pabb_accum.sv @@
// ----------------------------------------------------------------------------
// pabb_accum
// area accumulator and cross product multipliers at the top vertex
// ----------------------------------------------------------------------------
module pabb_accum import pabb_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic s2_valid,
  input  trk_t s2,
  input  logic s4_rdy,
  output logic s3_rdy,
  output logic s3_valid_r,
  output acc_t s3_r
);

  area_t acc_r;
  area_t acc_sum;
  logic  move;

  assign s3_rdy  = !s3_valid_r || s4_rdy;
  assign move    = s2_valid && s3_rdy;
  assign acc_sum = acc_r + area_t'(s2.edge_a) + area_t'(s2.edge_b);

  // accumulator, cleared once the closing vertex has passed
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r      <= '0;
      s3_valid_r <= 1'b0;
    end else begin
      if (s3_rdy) begin
        s3_valid_r <= s2_valid && s2.last;
      end
      if (move) begin
        acc_r <= s2.last ? '0 : acc_sum;
      end
    end
  end

  // result payload of the closing vertex
  always_ff @(posedge clk) begin
    if (move && s2.last) begin
      s3_r.area  <= acc_sum;
      s3_r.cr_a  <= prod_t'(s2.v1x) * prod_t'(s2.v2y);
      s3_r.cr_b  <= prod_t'(s2.v1y) * prod_t'(s2.v2x);
      s3_r.box   <= s2.box;
      s3_r.count <= s2.count;
      s3_r.ovf   <= s2.ovf;
    end
  end

endmodule

@@ hw/rtl/pabb_finish.sv @@
// ----------------------------------------------------------------------------
// pabb_finish
// orientation decision, signed area and the output register
// ----------------------------------------------------------------------------
module pabb_finish import pabb_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                s3_valid,
  input  acc_t                s3,
  input  logic                out_tready,
  output logic                s4_rdy,
  output logic                out_valid_r,
  output logic [OUT_BITS-1:0] out_data_r
);

  logic signed [CROSS_BITS-1:0] turn;
  logic                         few;
  logic                         cw;
  area_t                        area;

  assign s4_rdy = !out_valid_r || out_tready;

  // clockwise when too few vertices or the turn at the top is negative
  assign turn  = CROSS_BITS'(s3.cr_a) - CROSS_BITS'(s3.cr_b);
  assign few   = (s3.count < cnt_t'(MIN_FOR_ORIENT));
  assign cw    = few || turn[CROSS_BITS-1];
  assign area  = cw ? -s3.area : s3.area;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s4_rdy) begin
      out_valid_r <= s3_valid;
    end
  end

  // packed result, area in the lowest bits
  always_ff @(posedge clk) begin
    if (s4_rdy && s3_valid) begin
      out_data_r <= {s3.ovf, s3.count, s3.box.max_y, s3.box.min_y,
                     s3.box.max_x, s3.box.min_x, cw, area};
    end
  end

endmodule

@@ hw/rtl/polygon_area_orientation_bbox_core.sv @@
// ----------------------------------------------------------------------------
// polygon_area_orientation_bbox_core
// streaming shoelace area, orientation and bounding box of a polygon
// ----------------------------------------------------------------------------
// path: a closing vertex goes from the input register through the tracker and accumulator stages to the output register
// throughput: one vertex per cycle while the output is not stalled; results may leave back to back
// the pipeline stalls only when a result waits both in the output register
//   and in the stage before it
// reset: synchronous, active low; clears all valids and the polygon state
module polygon_area_orientation_bbox_core import pabb_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [IN_BITS-1:0]  in_tdata,   // x_coord, y_coord
  input  logic                in_tlast,   // last_vertex
  output logic                out_tvalid,
  input  logic                out_tready,
  // area_twice, clockwise, min_x, max_x, min_y, max_y, vertex_count,
  // count_overflow
  output logic [OUT_BITS-1:0] out_tdata
);

  logic   s1_valid_r;
  coord_t s1_x_r, s1_y_r;
  logic   s1_last_r;
  logic   s2_rdy, s3_rdy, s4_rdy;
  logic   s2_valid, s3_valid;
  trk_t   s2;
  acc_t   s3;

  assign in_tready = !s1_valid_r || s2_rdy;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_x_r    <= in_tdata[COORD_BITS-1:0];
      s1_y_r    <= in_tdata[IN_BITS-1:COORD_BITS];
      s1_last_r <= in_tlast;
    end
  end

  pabb_track u_track (
    .clk        (clk),
    .rst_n      (rst_n),
    .s1_valid   (s1_valid_r),
    .s1_x       (s1_x_r),
    .s1_y       (s1_y_r),
    .s1_last    (s1_last_r),
    .s3_rdy     (s3_rdy),
    .s2_rdy     (s2_rdy),
    .s2_valid_r (s2_valid),
    .s2_r       (s2)
  );

  pabb_accum u_accum (
    .clk        (clk),
    .rst_n      (rst_n),
    .s2_valid   (s2_valid),
    .s2         (s2),
    .s4_rdy     (s4_rdy),
    .s3_rdy     (s3_rdy),
    .s3_valid_r (s3_valid),
    .s3_r       (s3)
  );

  pabb_finish u_finish (
    .clk         (clk),
    .rst_n       (rst_n),
    .s3_valid    (s3_valid),
    .s3          (s3),
    .out_tready  (out_tready),
    .s4_rdy      (s4_rdy),
    .out_valid_r (out_tvalid),
    .out_data_r  (out_tdata)
  );

endmodule

@@ hw/rtl/pabb_checker.sv @@
// ----------------------------------------------------------------------------
// pabb_checker
// port-level checks of the polygon core, bound to the top level
// ----------------------------------------------------------------------------
module pabb_checker import pabb_pkg::*; (
  input logic                clk,
  input logic                rst_n,
  input logic                out_tvalid,
  input logic                out_tready,
  input logic [OUT_BITS-1:0] out_tdata
);

  logic signed [COORD_BITS-1:0] min_x, max_x, min_y, max_y;
  logic [CNT_BITS-1:0]          count;
  logic                         cw, ovf;

  assign cw    = out_tdata[48];
  assign min_x = out_tdata[64:49];
  assign max_x = out_tdata[80:65];
  assign min_y = out_tdata[96:81];
  assign max_y = out_tdata[112:97];
  assign count = out_tdata[126:113];
  assign ovf   = out_tdata[127];

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // the box is never inverted
  a_box: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (min_x <= max_x) && (min_y <= max_y))
    else $error("bounding box inverted");

  // overflow only with a saturated count
  a_ovf: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && ovf |-> count == CNT_BITS'(MAX_VERTICES))
    else $error("overflow without saturated count");

  // short polygons are reported clockwise, and have at least one vertex
  a_few: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && count < CNT_BITS'(MIN_FOR_ORIENT) |-> cw && count != '0)
    else $error("short polygon not clockwise");

endmodule

bind polygon_area_orientation_bbox_core pabb_checker u_pabb_checker (.*);
